// ===== sv/sm83alu_pkg.sv =====
`default_nettype none

package sm83alu_pkg;

    localparam int unsigned FUNC_W = 5;
    localparam int unsigned WORD_W = 16;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned BIDX_W = 3;
    localparam int unsigned FLAG_W = 4;

    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    localparam logic [FLAG_W-1:0] FLAGS_RESET = 4'hB;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD    = 5'd0,
        FUNC_ADC    = 5'd1,
        FUNC_SUB    = 5'd2,
        FUNC_SBC    = 5'd3,
        FUNC_AND    = 5'd4,
        FUNC_XOR    = 5'd5,
        FUNC_OR     = 5'd6,
        FUNC_CP     = 5'd7,
        FUNC_INC    = 5'd8,
        FUNC_DEC    = 5'd9,
        FUNC_ADD16  = 5'd10,
        FUNC_ADDSP  = 5'd11,
        FUNC_RLC    = 5'd12,
        FUNC_RRC    = 5'd13,
        FUNC_RL     = 5'd14,
        FUNC_RR     = 5'd15,
        FUNC_SLA    = 5'd16,
        FUNC_SRA    = 5'd17,
        FUNC_SWAP   = 5'd18,
        FUNC_SRL    = 5'd19,
        FUNC_BIT    = 5'd20,
        FUNC_RES    = 5'd21,
        FUNC_SET    = 5'd22
    } t_func;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [WORD_W-1:0] dest_value;
        logic [WORD_W-1:0] source_value;
        logic [BIDX_W-1:0] bit_index;
    } t_alu_req;

    typedef struct packed {
        logic [WORD_W-1:0] result_value;
        logic [FLAG_W-1:0] flags_out;
    } t_alu_rsp;

endpackage

`default_nettype wire

// ===== sv/sm83alu_in_if.sv =====
`default_nettype none

interface sm83alu_in_if;
    logic                               valid;
    logic                               ready;
    logic [sm83alu_pkg::FUNC_W-1:0]     func;
    logic [sm83alu_pkg::WORD_W-1:0]     dest_value;
    logic [sm83alu_pkg::WORD_W-1:0]     source_value;
    logic [sm83alu_pkg::BIDX_W-1:0]     bit_index;

    modport source (
        output valid, func, dest_value, source_value, bit_index,
        input  ready
    );

    modport sink (
        input  valid, func, dest_value, source_value, bit_index,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/sm83alu_out_if.sv =====
`default_nettype none

interface sm83alu_out_if;
    logic                               valid;
    logic                               ready;
    logic [sm83alu_pkg::WORD_W-1:0]     result_value;
    logic [sm83alu_pkg::FLAG_W-1:0]     flags_out;

    modport source (
        output valid, result_value, flags_out,
        input  ready
    );

    modport sink (
        input  valid, result_value, flags_out,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/sm83alu_core.sv =====
`default_nettype none

module sm83alu_core (
    input  wire sm83alu_pkg::t_alu_req                i_req,
    input  wire logic [sm83alu_pkg::FLAG_W-1:0]       i_flags,
    output sm83alu_pkg::t_alu_rsp                     o_rsp
);

    logic [7:0]  d;
    logic [7:0]  s;
    logic        cin;
    logic        t_add;
    logic        t_sub;
    logic [8:0]  add9;
    logic [4:0]  addh;
    logic [8:0]  sub9;
    logic [4:0]  subh;
    logic [16:0] add17;
    logic [12:0] add13;
    logic [8:0]  sp9;
    logic [4:0]  sph;
    logic [15:0] sp16;
    logic [7:0]  inc8;
    logic [7:0]  dec8;
    logic [7:0]  bmask;
    logic [7:0]  r8;
    logic        wide;
    logic        use_z8;

    assign d     = i_req.dest_value[7:0];
    assign s     = i_req.source_value[7:0];
    assign cin   = i_flags[sm83alu_pkg::FLAG_C];
    assign t_add = (i_req.func == sm83alu_pkg::FUNC_ADC) ? cin : 1'b0;
    assign t_sub = (i_req.func == sm83alu_pkg::FUNC_SBC) ? cin : 1'b0;
    assign add9  = {1'b0, d} + {1'b0, s} + {8'd0, t_add};
    assign addh  = {1'b0, d[3:0]} + {1'b0, s[3:0]} + {4'd0, t_add};
    assign sub9  = {1'b0, d} - {1'b0, s} - {8'd0, t_sub};
    assign subh  = {1'b0, d[3:0]} - {1'b0, s[3:0]} - {4'd0, t_sub};
    assign add17 = {1'b0, i_req.dest_value} + {1'b0, i_req.source_value};
    assign add13 = {1'b0, i_req.dest_value[11:0]} + {1'b0, i_req.source_value[11:0]};
    assign sp9   = {1'b0, d} + {1'b0, s};
    assign sph   = {1'b0, d[3:0]} + {1'b0, s[3:0]};
    assign sp16  = i_req.dest_value + {{8{s[7]}}, s};
    assign inc8  = d + 8'd1;
    assign dec8  = d - 8'd1;
    assign bmask = 8'd1 << i_req.bit_index;

    always_comb begin
        r8     = d;
        wide   = 1'b0;
        use_z8 = 1'b0;
        o_rsp.flags_out = i_flags;
        case (i_req.func)
            sm83alu_pkg::FUNC_ADD, sm83alu_pkg::FUNC_ADC: begin
                r8     = add9[7:0];
                use_z8 = 1'b1;
                o_rsp.flags_out = {1'b0, 1'b0, addh[4], add9[8]};
            end
            sm83alu_pkg::FUNC_SUB, sm83alu_pkg::FUNC_SBC: begin
                r8     = sub9[7:0];
                use_z8 = 1'b1;
                o_rsp.flags_out = {1'b0, 1'b1, subh[4], sub9[8]};
            end
            sm83alu_pkg::FUNC_CP: begin
                r8 = d;
                o_rsp.flags_out = {(sub9[7:0] == 8'd0), 1'b1, subh[4], sub9[8]};
            end
            sm83alu_pkg::FUNC_AND: begin
                r8     = d & s;
                use_z8 = 1'b1;
                o_rsp.flags_out = 4'b0010;
            end
            sm83alu_pkg::FUNC_XOR: begin
                r8     = d ^ s;
                use_z8 = 1'b1;
                o_rsp.flags_out = 4'b0000;
            end
            sm83alu_pkg::FUNC_OR: begin
                r8     = d | s;
                use_z8 = 1'b1;
                o_rsp.flags_out = 4'b0000;
            end
            sm83alu_pkg::FUNC_INC: begin
                r8     = inc8;
                use_z8 = 1'b1;
                o_rsp.flags_out = {1'b0, 1'b0, (d[3:0] == 4'hF), cin};
            end
            sm83alu_pkg::FUNC_DEC: begin
                r8     = dec8;
                use_z8 = 1'b1;
                o_rsp.flags_out = {1'b0, 1'b1, (d[3:0] == 4'h0), cin};
            end
            sm83alu_pkg::FUNC_ADD16: begin
                wide = 1'b1;
                o_rsp.flags_out = {i_flags[sm83alu_pkg::FLAG_Z], 1'b0, add13[12], add17[16]};
            end
            sm83alu_pkg::FUNC_ADDSP: begin
                wide = 1'b1;
                o_rsp.flags_out = {1'b0, 1'b0, sph[4], sp9[8]};
            end
            sm83alu_pkg::FUNC_RLC: begin
                r8     = {d[6:0], d[7]};
                use_z8 = 1'b1;
                o_rsp.flags_out = {3'b000, d[7]};
            end
            sm83alu_pkg::FUNC_RRC: begin
                r8     = {d[0], d[7:1]};
                use_z8 = 1'b1;
                o_rsp.flags_out = {3'b000, d[0]};
            end
            sm83alu_pkg::FUNC_RL: begin
                r8     = {d[6:0], cin};
                use_z8 = 1'b1;
                o_rsp.flags_out = {3'b000, d[7]};
            end
            sm83alu_pkg::FUNC_RR: begin
                r8     = {cin, d[7:1]};
                use_z8 = 1'b1;
                o_rsp.flags_out = {3'b000, d[0]};
            end
            sm83alu_pkg::FUNC_SLA: begin
                r8     = {d[6:0], 1'b0};
                use_z8 = 1'b1;
                o_rsp.flags_out = {3'b000, d[7]};
            end
            sm83alu_pkg::FUNC_SRA: begin
                r8     = {d[7], d[7:1]};
                use_z8 = 1'b1;
                o_rsp.flags_out = {3'b000, d[0]};
            end
            sm83alu_pkg::FUNC_SWAP: begin
                r8     = {d[3:0], d[7:4]};
                use_z8 = 1'b1;
                o_rsp.flags_out = 4'b0000;
            end
            sm83alu_pkg::FUNC_SRL: begin
                r8     = {1'b0, d[7:1]};
                use_z8 = 1'b1;
                o_rsp.flags_out = {3'b000, d[0]};
            end
            sm83alu_pkg::FUNC_BIT: begin
                r8 = d;
                o_rsp.flags_out = {~d[i_req.bit_index], 1'b0, 1'b1, cin};
            end
            sm83alu_pkg::FUNC_RES: begin
                r8 = d & ~bmask;
            end
            sm83alu_pkg::FUNC_SET: begin
                r8 = d | bmask;
            end
            default: begin
                wide = 1'b1;
            end
        endcase

        if (use_z8) begin
            o_rsp.flags_out[sm83alu_pkg::FLAG_Z] = (r8 == 8'd0);
        end

        if (wide) begin
            case (i_req.func)
                sm83alu_pkg::FUNC_ADD16: o_rsp.result_value = add17[15:0];
                sm83alu_pkg::FUNC_ADDSP: o_rsp.result_value = sp16;
                default:                 o_rsp.result_value = i_req.dest_value;
            endcase
        end else begin
            o_rsp.result_value = {8'd0, r8};
        end
    end

endmodule

`default_nettype wire

// ===== sv/sm83_alu_with_flags_top.sv =====
// SM83 ALU (8-bit operations plus the 16-bit ADD16 and ADDSP) with its four-bit flag register (Z, N, H, C).
//
// Operations arrive on the i_in channel (valid/ready) and results leave on
// the o_out channel (valid/ready); a transfer happens on a rising edge of
// i_clk where valid and ready are both high. Each operation carries the
// function code, the destination and source operands and a bit index.
// Each result carries the new destination value and the new flags.
//
// An operation is captured in an input register, and its result is then
// loaded into an output register. One operation is accepted every cycle
// while the receiver keeps o_out.ready high, set by the single compute
// stage that reads the flag register and writes it back when the result
// is loaded.
//
// When the receiver holds o_out.ready low, the output register holds its
// result and the input register holds one more operation; i_in.ready then
// drops until the result is taken.
//
// Reset (i_rst_n low, synchronous) empties both registers and sets the
// flags to Z, H and C.

`default_nettype none

module sm83_alu_with_flags_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    sm83alu_in_if.sink         i_in,
    sm83alu_out_if.source      o_out
);

    logic                                r_in_valid;
    sm83alu_pkg::t_alu_req               r_req;
    logic                                r_out_valid;
    sm83alu_pkg::t_alu_rsp               r_rsp;
    logic [sm83alu_pkg::FLAG_W-1:0]      r_flags;
    sm83alu_pkg::t_alu_rsp               n_rsp;
    logic                                advance;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    sm83alu_core u_core (
        .i_req   (r_req),
        .i_flags (r_flags),
        .o_rsp   (n_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= sm83alu_pkg::FLAGS_RESET;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_flags     <= n_rsp.flags_out;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_req.func         <= i_in.func;
            r_req.dest_value   <= i_in.dest_value;
            r_req.source_value <= i_in.source_value;
            r_req.bit_index    <= i_in.bit_index;
        end
        if (advance) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.result_value = r_rsp.result_value;
    assign o_out.flags_out    = r_rsp.flags_out;

    // The flag register always matches the flags of the result on display.
    a_flags_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_flags == r_rsp.flags_out))
        else $error("flag register differs from presented flags");

    // A held operation moves to an empty output register on the next edge.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |=> r_out_valid)
        else $error("operation did not advance into empty output register");

    // Flags change only when a result is loaded.
    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!advance && $past(i_rst_n)) |=> $stable(r_flags))
        else $error("flag register changed without a result load");

    // Reset leaves Z, H and C set and no result pending.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_flags == sm83alu_pkg::FLAGS_RESET && !r_out_valid))
        else $error("reset state incorrect");

endmodule

`default_nettype wire
